@@ hw/rtl/fwcp_pkg.sv @@
`timescale 1ns / 1ps
// Package for the flash write chunk planner.
// Holds the controller state type, chunk and status codes, and the
// command and status structs between controller and datapath. No dependencies.
package fwcp_pkg;

   localparam int unsigned MAX_LEN     = 1024;
   localparam int unsigned QUAD_BYTES  = 16;
   localparam int unsigned BURST_BYTES = 128;

   localparam logic [31:0] REGION_BASE_RESET  = 32'h0800_0000;
   localparam logic [31:0] REGION_BYTES_RESET = 32'h0020_0000;

   // Register indexes on the configuration port.
   localparam logic REG_REGION_BASE  = 1'b0;
   localparam logic REG_REGION_BYTES = 1'b1;

   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_QUAD  = 2'd1;
   localparam logic [1:0] KIND_BURST = 2'd2;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_BAD_ADDR = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic load;
      logic emit_chunk;
      logic emit_invalid;
      logic emit_empty;
   } cmd_type;

   typedef struct packed {
      logic in_region;
      logic zero_len;
      logic chunk_last;
      logic out_free;
   } stat_type;

endpackage

@@ hw/rtl/fwcp_req_if.sv @@
`timescale 1ns / 1ps
// Request channel of the flash write chunk planner: valid, ready and payload.
// No dependencies.
interface fwcp_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] start_address;
   logic [10:0] byte_count;

   modport source (output valid, output start_address, output byte_count, input ready);
   modport sink   (input valid, input start_address, input byte_count, output ready);
endinterface

@@ hw/rtl/fwcp_rsp_if.sv @@
`timescale 1ns / 1ps
// Result channel of the flash write chunk planner: valid, ready and one
// chunk descriptor. No dependencies.
interface fwcp_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [31:0] chunk_address;
   logic [1:0]  chunk_kind;
   logic [15:0] byte_enable;
   logic [9:0]  source_offset;
   logic [7:0]  data_bytes;
   logic        last;

   modport source (output valid, output status, output chunk_address, output chunk_kind,
                   output byte_enable, output source_offset, output data_bytes,
                   output last, input ready);
   modport sink   (input valid, input status, input chunk_address, input chunk_kind,
                   input byte_enable, input source_offset, input data_bytes,
                   input last, output ready);
endinterface

@@ hw/rtl/fwcp_csr.sv @@
`timescale 1ns / 1ps
// Configuration registers of the flash write chunk planner (region base and size)
// behind an APB-style port. Depends on fwcp_pkg.
module fwcp_csr
   import fwcp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [31:0] region_base,
   output logic [31:0] region_bytes
);

   logic [31:0] region_base_ff,  region_base_in;
   logic [31:0] region_bytes_ff, region_bytes_in;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      region_base_in  = region_base_ff;
      region_bytes_in = region_bytes_ff;
      if (wr_en) begin
         if (paddr[2] == REG_REGION_BASE) begin
            region_base_in = pwdata;
         end else begin
            region_bytes_in = pwdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_base_ff  <= REGION_BASE_RESET;
         region_bytes_ff <= REGION_BYTES_RESET;
      end else begin
         region_base_ff  <= region_base_in;
         region_bytes_ff <= region_bytes_in;
      end
   end

   always_comb begin
      prdata = 32'd0;
      if (paddr[2] == REG_REGION_BASE) begin
         prdata = region_base_ff;
      end else begin
         prdata = region_bytes_ff;
      end
   end

   assign region_base  = region_base_ff;
   assign region_bytes = region_bytes_ff;

endmodule

@@ hw/rtl/fwcp_dpath.sv @@
`timescale 1ns / 1ps
// Datapath of the flash write chunk planner: request registers, chunk
// calculation and the result output register. Depends on fwcp_pkg.
module fwcp_dpath
   import fwcp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic [31:0] region_base,
   input  logic [31:0] region_bytes,
   input  logic [31:0] req_start_address,
   input  logic [10:0] req_byte_count,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output logic        rsp_status,
   output logic [31:0] rsp_chunk_address,
   output logic [1:0]  rsp_chunk_kind,
   output logic [15:0] rsp_byte_enable,
   output logic [9:0]  rsp_source_offset,
   output logic [7:0]  rsp_data_bytes,
   output logic        rsp_last
);

   localparam logic [10:0] MAX_LEN_W = 11'(MAX_LEN);

   // The address register is loaded unaligned; after the first chunk it is
   // always quad aligned, so its low bits give the lane of the leading piece.
   logic [31:0] addr_ff, addr_in;
   logic [10:0] len_ff,  len_in;
   logic [10:0] src_ff,  src_in;

   logic        valid_ff, valid_in;
   logic        status_ff, status_in;
   logic [31:0] caddr_ff, caddr_in;
   logic [1:0]  kind_ff, kind_in;
   logic [15:0] be_ff, be_in;
   logic [9:0]  off_ff, off_in;
   logic [7:0]  nb_ff, nb_in;
   logic        last_ff, last_in;

   logic [3:0]  lane;
   logic [31:0] aligned;
   logic [4:0]  room;
   logic [7:0]  wr;
   logic [15:0] be;
   logic [1:0]  kind;
   logic [10:0] len_rest;
   logic [32:0] region_end;
   logic [16:0] low_mask;

   assign lane    = addr_ff[3:0];
   assign aligned = {addr_ff[31:4], 4'h0};
   assign room    = 5'(QUAD_BYTES) - {1'b0, lane};

   always_comb begin
      wr       = 8'd0;
      kind     = KIND_QUAD;
      low_mask = 17'd0;
      be       = 16'hFFFF;
      if (lane != 4'd0) begin
         if (len_ff < {6'd0, room}) begin
            wr = len_ff[7:0];
         end else begin
            wr = {3'd0, room};
         end
         low_mask = (17'd1 << wr[4:0]) - 17'd1;
         be       = low_mask[15:0] << lane;
      end else if (len_ff >= 11'(BURST_BYTES) && addr_ff[6:0] == 7'd0) begin
         wr   = 8'(BURST_BYTES);
         kind = KIND_BURST;
      end else if (len_ff < 11'(QUAD_BYTES)) begin
         // Short tail sits in the low lanes; the upper ones are padded.
         wr       = len_ff[7:0];
         low_mask = (17'd1 << wr[4:0]) - 17'd1;
         be       = low_mask[15:0];
      end else begin
         wr = 8'(QUAD_BYTES);
      end
   end

   assign len_rest   = len_ff - {3'd0, wr};
   assign region_end = {1'b0, region_base} + {1'b0, region_bytes};

   assign stat.in_region  = (addr_ff >= region_base) && ({1'b0, addr_ff} < region_end);
   assign stat.zero_len   = (len_ff == 11'd0);
   assign stat.chunk_last = (len_rest == 11'd0);
   assign stat.out_free   = !valid_ff || rsp_ready;

   always_comb begin
      addr_in = addr_ff;
      len_in  = len_ff;
      src_in  = src_ff;
      if (cmd.load) begin
         addr_in = req_start_address;
         len_in  = (req_byte_count > MAX_LEN_W) ? MAX_LEN_W : req_byte_count;
         src_in  = 11'd0;
      end else if (cmd.emit_chunk) begin
         addr_in = (kind == KIND_BURST) ? aligned + 32'(BURST_BYTES)
                                        : aligned + 32'(QUAD_BYTES);
         len_in  = len_rest;
         src_in  = src_ff + {3'd0, wr};
      end
   end

   always_comb begin
      valid_in  = valid_ff && !rsp_ready;
      status_in = status_ff;
      caddr_in  = caddr_ff;
      kind_in   = kind_ff;
      be_in     = be_ff;
      off_in    = off_ff;
      nb_in     = nb_ff;
      last_in   = last_ff;
      if (cmd.emit_chunk) begin
         valid_in  = 1'b1;
         status_in = STATUS_OK;
         caddr_in  = aligned;
         kind_in   = kind;
         be_in     = be;
         off_in    = src_ff[9:0];
         nb_in     = wr;
         last_in   = (len_rest == 11'd0);
      end else if (cmd.emit_invalid || cmd.emit_empty) begin
         valid_in  = 1'b1;
         status_in = cmd.emit_invalid ? STATUS_BAD_ADDR : STATUS_OK;
         caddr_in  = 32'd0;
         kind_in   = KIND_NONE;
         be_in     = 16'd0;
         off_in    = 10'd0;
         nb_in     = 8'd0;
         last_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      len_ff    <= len_in;
      src_ff    <= src_in;
      status_ff <= status_in;
      caddr_ff  <= caddr_in;
      kind_ff   <= kind_in;
      be_ff     <= be_in;
      off_ff    <= off_in;
      nb_ff     <= nb_in;
      last_ff   <= last_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_chunk_address = caddr_ff;
   assign rsp_chunk_kind    = kind_ff;
   assign rsp_byte_enable   = be_ff;
   assign rsp_source_offset = off_ff;
   assign rsp_data_bytes    = nb_ff;
   assign rsp_last          = last_ff;

endmodule

@@ hw/rtl/fwcp_ctrl.sv @@
`timescale 1ns / 1ps
// Controller of the flash write chunk planner: takes a request, checks it
// and steps the datapath one chunk per free output slot. Depends on fwcp_pkg.
module fwcp_ctrl
   import fwcp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.out_free) begin
               if (!stat.in_region) begin
                  cmd.emit_invalid = 1'b1;
                  state_in         = ST_IDLE;
               end else if (stat.zero_len) begin
                  cmd.emit_empty = 1'b1;
                  state_in       = ST_IDLE;
               end else begin
                  cmd.emit_chunk = 1'b1;
                  state_in       = stat.chunk_last ? ST_IDLE : ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (stat.out_free) begin
               cmd.emit_chunk = 1'b1;
               if (stat.chunk_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ hw/rtl/flash_write_chunk_planner.sv @@
`timescale 1ns / 1ps
// Flash write chunk planner: splits a write request into quad word and burst operations.
// The request is loaded into the address and length registers, then the first result is
// registered once the output register is free. N results (at most 16 for 1024 bytes) follow
// at one chunk per cycle while the output register drains; no new request is taken meanwhile.
// Reset (synchronous, active high) returns the controller to idle, empties the output
// register and restores the region registers to 0x08000000 and 0x200000.
module flash_write_chunk_planner
   import fwcp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   fwcp_req_if.sink    req_chan,
   fwcp_rsp_if.source  rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cmd_type     cmd;
   stat_type    stat;
   logic [31:0] region_base;
   logic [31:0] region_bytes;
   logic        req_ready;

   fwcp_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (csr_psel),
      .penable      (csr_penable),
      .pwrite       (csr_pwrite),
      .paddr        (csr_paddr),
      .pwdata       (csr_pwdata),
      .prdata       (csr_prdata),
      .pready       (csr_pready),
      .region_base  (region_base),
      .region_bytes (region_bytes)
   );

   fwcp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   assign req_chan.ready = req_ready;

   fwcp_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .region_base       (region_base),
      .region_bytes      (region_bytes),
      .req_start_address (req_chan.start_address),
      .req_byte_count    (req_chan.byte_count),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_status        (rsp_chan.status),
      .rsp_chunk_address (rsp_chan.chunk_address),
      .rsp_chunk_kind    (rsp_chan.chunk_kind),
      .rsp_byte_enable   (rsp_chan.byte_enable),
      .rsp_source_offset (rsp_chan.source_offset),
      .rsp_data_bytes    (rsp_chan.data_bytes),
      .rsp_last          (rsp_chan.last)
   );

endmodule

@@ sim/flash_write_chunk_planner_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the flash write chunk planner: directed and random write
// requests, with random stalls on both channels, checked against an in-bench chunk predictor.
// Depends on fwcp_pkg, fwcp_req_if, fwcp_rsp_if and flash_write_chunk_planner.
module flash_write_chunk_planner_test;
   import fwcp_pkg::*;

   typedef struct packed {
      logic        status;
      logic [31:0] chunk_address;
      logic [1:0]  chunk_kind;
      logic [15:0] byte_enable;
      logic [9:0]  source_offset;
      logic [7:0]  data_bytes;
      logic        last;
   } chunk_rec;

   typedef struct packed {
      logic [31:0] start;
      logic [10:0] count;
      logic        typed;
      chunk_rec    want;
   } directed_row;

   localparam chunk_rec BAD_ADDR_RSP =
      '{STATUS_BAD_ADDR, 32'd0, KIND_NONE, 16'd0, 10'd0, 8'd0, 1'b1};
   localparam chunk_rec EMPTY_RSP =
      '{STATUS_OK, 32'd0, KIND_NONE, 16'd0, 10'd0, 8'd0, 1'b1};
   localparam chunk_rec NO_RSP = '0;

   // Rows run under the reset region of 0x08000000 to 0x081FFFFF.
   localparam directed_row DIRECTED [18] = '{
      '{32'h0800_0000, 11'd0,    1'b1, EMPTY_RSP},
      '{32'h07FF_FFFF, 11'd16,   1'b1, BAD_ADDR_RSP},
      '{32'h0820_0000, 11'd16,   1'b1, BAD_ADDR_RSP},
      '{32'h0000_0000, 11'd2047, 1'b1, BAD_ADDR_RSP},
      '{32'hFFFF_FFFF, 11'd1024, 1'b1, BAD_ADDR_RSP},
      '{32'h0800_0000, 11'd16,   1'b1,
        '{STATUS_OK, 32'h0800_0000, KIND_QUAD, 16'hFFFF, 10'd0, 8'd16, 1'b1}},
      '{32'h0800_0000, 11'd128,  1'b1,
        '{STATUS_OK, 32'h0800_0000, KIND_BURST, 16'hFFFF, 10'd0, 8'd128, 1'b1}},
      '{32'h0800_0000, 11'd1,    1'b1,
        '{STATUS_OK, 32'h0800_0000, KIND_QUAD, 16'h0001, 10'd0, 8'd1, 1'b1}},
      '{32'h081F_FFFF, 11'd1,    1'b1,
        '{STATUS_OK, 32'h081F_FFF0, KIND_QUAD, 16'h8000, 10'd0, 8'd1, 1'b1}},
      '{32'h0800_0008, 11'd8,    1'b1,
        '{STATUS_OK, 32'h0800_0000, KIND_QUAD, 16'hFF00, 10'd0, 8'd8, 1'b1}},
      '{32'h0800_0003, 11'd5,    1'b0, NO_RSP},
      '{32'h0800_000F, 11'd17,   1'b0, NO_RSP},
      '{32'h0800_0070, 11'd200,  1'b0, NO_RSP},
      '{32'h0800_0010, 11'd1023, 1'b0, NO_RSP},
      '{32'h0800_0000, 11'd1024, 1'b0, NO_RSP},
      '{32'h0800_0001, 11'd2047, 1'b0, NO_RSP},
      '{32'h0800_0000, 11'd1025, 1'b0, NO_RSP},
      '{32'h081F_FF81, 11'd300,  1'b0, NO_RSP}
   };

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   fwcp_req_if req_chan ();
   fwcp_rsp_if rsp_chan ();

   flash_write_chunk_planner u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   chunk_rec    expected_chunks [$];
   logic [31:0] region_base_q;
   logic [31:0] region_bytes_q;
   int          mismatches;
   bit          no_idle;
   bit          hold_results;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("flash_write_chunk_planner test failed");
      $finish;
   end

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Works out the chunk descriptors of one write request under the current region.
   function automatic void plan_write(input logic [31:0] start, input logic [10:0] count);
      logic [32:0] region_end;
      logic [31:0] addr;
      logic [31:0] mask;
      logic [3:0]  lane;
      logic [10:0] remaining;
      logic [9:0]  src;
      logic [1:0]  kind;
      int unsigned take;
      int          n;
      region_end = {1'b0, region_base_q} + {1'b0, region_bytes_q};
      if (start < region_base_q || {1'b0, start} >= region_end) begin
         expected_chunks.push_back(BAD_ADDR_RSP);
         return;
      end
      remaining = (count > MAX_LEN) ? 11'(MAX_LEN) : count;
      if (remaining == 0) begin
         expected_chunks.push_back(EMPTY_RSP);
         return;
      end
      lane = start[3:0];
      addr = {start[31:4], 4'd0};
      src  = '0;
      n    = 0;
      while (remaining > 0 && n < 24) begin
         if (lane != 0) begin
            take = QUAD_BYTES - lane;
            if (take > remaining) take = remaining;
            mask = ((32'd1 << take) - 32'd1) << lane;
            kind = KIND_QUAD;
         end else if (remaining >= BURST_BYTES && addr[6:0] == 7'd0) begin
            take = BURST_BYTES;
            mask = 32'hFFFF;
            kind = KIND_BURST;
         end else if (remaining < QUAD_BYTES) begin
            take = remaining;
            mask = (32'd1 << take) - 32'd1;
            kind = KIND_QUAD;
         end else begin
            take = QUAD_BYTES;
            mask = 32'hFFFF;
            kind = KIND_QUAD;
         end
         remaining = remaining - 11'(take);
         expected_chunks.push_back('{STATUS_OK, addr, kind, mask[15:0], src, 8'(take),
                                     remaining == 0});
         addr = addr + ((kind == KIND_BURST) ? 32'(BURST_BYTES) : 32'(QUAD_BYTES));
         src  = src + 10'(take);
         lane = '0;
         n++;
      end
   endfunction

   function automatic int pick_idle(input bit allow_zero);
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55 && allow_zero) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Mostly addresses inside the region, some on its edges and some anywhere.
   function automatic logic [31:0] pick_start();
      logic [63:0] span;
      logic [63:0] stop;
      int          r;
      span = 64'h1_0000_0000 - region_base_q;
      if (region_bytes_q < span) span = region_bytes_q;
      stop = region_base_q + region_bytes_q;
      r = $urandom_range(0, 99);
      if (r < 60) return region_base_q + 32'(64'($urandom) % span);
      if (r < 75) return region_base_q + 32'(span - 1 - (64'($urandom_range(0, 2047)) % span));
      if (r < 85) begin
         case ($urandom_range(0, 3))
            0: return region_base_q - 32'd1;
            1: return region_base_q;
            2: return 32'(stop - 1);
            default: return 32'(stop);
         endcase
      end
      return $urandom;
   endfunction

   function automatic logic [10:0] pick_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 11'($urandom_range(0, 64));
      if (r < 70) return 11'($urandom_range(65, 1024));
      if (r < 80) return 11'($urandom_range(1025, 2047));
      case ($urandom_range(0, 7))
         0: return 11'd0;
         1: return 11'd1;
         2: return 11'd15;
         3: return 11'd16;
         4: return 11'd127;
         5: return 11'd128;
         6: return 11'd1024;
         default: return 11'd2047;
      endcase
   endfunction

   // One APB transfer; a read compares the returned data with value.
   task automatic csr_access(input bit is_write, input logic reg_index,
                             input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= {reg_index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (is_write) begin
         if (reg_index == REG_REGION_BASE) region_base_q = value;
         else region_bytes_q = value;
      end else begin
         check_field("csr_prdata", value, csr_prdata);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Returns at the edge where the request is taken.
   task automatic issue_write(input logic [31:0] start, input logic [10:0] count);
      req_chan.valid         <= 1'b1;
      req_chan.start_address <= start;
      req_chan.byte_count    <= count;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // A zero gap leaves valid high so that the next request follows back to back.
   task automatic rest_requests(input int gap);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      while (expected_chunks.size() != 0) @(posedge clock);
   endtask

   task automatic run_phase(input logic [31:0] base, input logic [31:0] size,
                            input int items, input bit steady, input bit hold);
      logic [31:0] start;
      logic [10:0] count;
      int          gap;
      wait_drained();
      csr_access(1'b1, REG_REGION_BASE, base);
      csr_access(1'b1, REG_REGION_BYTES, size);
      csr_access(1'b0, REG_REGION_BASE, base);
      csr_access(1'b0, REG_REGION_BYTES, size);
      no_idle      = steady;
      hold_results = hold;
      for (int i = 0; i < items; i++) begin
         start = pick_start();
         count = pick_count();
         issue_write(start, count);
         plan_write(start, count);
         gap = (i == items / 2) ? 1 : pick_idle(1'b1);
         rest_requests(gap);
         // Halfway through, the sender stops until the block has drained.
         if (i == items / 2) wait_drained();
      end
      req_chan.valid <= 1'b0;
      no_idle = 1'b0;
   endtask

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      int stall_left;
      stall_left     = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_results) begin
            stall_left   = 300;
            hold_results = 1'b0;
         end
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else if (no_idle || $urandom_range(0, 99) < 65) begin
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= 1'b0;
            stall_left = pick_idle(1'b0) - 1;
         end
      end
   end

   always @(posedge clock) begin
      chunk_rec want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_chunks.size() == 0) begin
            $display("%0t ns: unexpected result, chunk_address 0x%0h", $time,
                     rsp_chan.chunk_address);
            mismatches++;
         end else begin
            want = expected_chunks.pop_front();
            check_field("status", want.status, rsp_chan.status);
            check_field("chunk_address", want.chunk_address, rsp_chan.chunk_address);
            check_field("chunk_kind", want.chunk_kind, rsp_chan.chunk_kind);
            check_field("byte_enable", want.byte_enable, rsp_chan.byte_enable);
            check_field("source_offset", want.source_offset, rsp_chan.source_offset);
            check_field("data_bytes", want.data_bytes, rsp_chan.data_bytes);
            check_field("last", want.last, rsp_chan.last);
         end
      end
   end

   initial begin
      reset                  = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.start_address = '0;
      req_chan.byte_count    = '0;
      csr_psel               = 1'b0;
      csr_penable            = 1'b0;
      csr_pwrite             = 1'b0;
      csr_paddr              = '0;
      csr_pwdata             = '0;
      region_base_q          = REGION_BASE_RESET;
      region_bytes_q         = REGION_BYTES_RESET;
      mismatches             = 0;
      no_idle                = 1'b0;
      hold_results           = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      csr_access(1'b0, REG_REGION_BASE, REGION_BASE_RESET);
      csr_access(1'b0, REG_REGION_BYTES, REGION_BYTES_RESET);
      foreach (DIRECTED[i]) begin
         issue_write(DIRECTED[i].start, DIRECTED[i].count);
         if (DIRECTED[i].typed) expected_chunks.push_back(DIRECTED[i].want);
         else plan_write(DIRECTED[i].start, DIRECTED[i].count);
         rest_requests(pick_idle(1'b1));
      end
      req_chan.valid <= 1'b0;

      run_phase(32'h0000_0000, 32'hFFFF_FFFF, 35, 1'b1, 1'b0);
      // Region running past the top of the address space, so chunks wrap to zero.
      run_phase(32'hFFFF_FF00, 32'hFFFF_FFFF, 35, 1'b0, 1'b0);
      run_phase(32'hFFFF_FFF0, 32'd16, 30, 1'b0, 1'b0);
      run_phase(32'h0000_0000, 32'd16, 30, 1'b0, 1'b0);
      run_phase($urandom, $urandom_range(16, 32'hFFFF_FFFF), 40, 1'b0, 1'b0);
      run_phase(REGION_BASE_RESET, REGION_BYTES_RESET, 40, 1'b1, 1'b1);
      run_phase(32'h2000_0004, 32'd4096, 40, 1'b0, 1'b0);
      run_phase($urandom & 32'hFFFF_F000, $urandom_range(16, 65536), 40, 1'b0, 1'b0);
      run_phase(REGION_BASE_RESET, REGION_BYTES_RESET, 30, 1'b0, 1'b0);

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("flash_write_chunk_planner test passed");
      end else begin
         $display("flash_write_chunk_planner test failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/fwcp_pkg.sv
hw/rtl/fwcp_req_if.sv
hw/rtl/fwcp_rsp_if.sv
hw/rtl/fwcp_csr.sv
hw/rtl/fwcp_dpath.sv
hw/rtl/fwcp_ctrl.sv
hw/rtl/flash_write_chunk_planner.sv
sim/flash_write_chunk_planner_test.sv
